/* rtl/assert_macros.svh */
// Concurrent assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* rtl/twrcl_pkg.sv */
package twrcl_pkg;

  localparam int unsigned AddrW      = 27;
  localparam int unsigned DataW      = 32;
  localparam int unsigned CacheBytes = 16384;
  localparam int unsigned LineWords  = 8;
  localparam int unsigned NumWays    = 2;
  localparam int unsigned QueueDepth = 2;

  localparam int unsigned LineBytes = LineWords * 4;
  localparam int unsigned Sets      = CacheBytes / (LineBytes * NumWays);
  localparam int unsigned WayWords  = Sets * LineWords;
  localparam int unsigned WordW     = $clog2(LineWords);
  localparam int unsigned OffW      = $clog2(LineBytes);
  localparam int unsigned IdxW      = $clog2(Sets);
  localparam int unsigned TagW      = AddrW - OffW - IdxW;
  localparam int unsigned PosW      = $clog2(WayWords);
  localparam int unsigned QPtrW     = $clog2(QueueDepth);
  localparam int unsigned QCntW     = $clog2(QueueDepth + 1);

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_FILL   = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TAG,
    ST_DATA
  } state_e;

  // Decoded request as it leaves the front end.
  typedef struct packed {
    op_e              op;
    logic             done;
    logic [TagW-1:0]  tag;
    logic [IdxW-1:0]  idx;
    logic [WordW-1:0] word;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] data;
    logic             way;
  } item_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             hit;
    logic             fill_request;
    logic [AddrW-1:0] request_address;
    logic             request_way;
    logic             waiting;
  } result_t;

endpackage

/* rtl/twrcl_ram.sv */
module twrcl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/twrcl_front.sv */
module twrcl_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    func_i,
  input  logic [26:0]             address_i,
  input  logic [31:0]             fill_data_i,
  input  logic                    fill_way_i,
  input  logic                    fill_complete_i,
  output logic                    head_valid_o,
  output twrcl_pkg::item_t        head_o,
  input  logic                    pop_i
);

  import twrcl_pkg::*;

  item_t            q_mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  item_t            dec;
  logic             push;

  // Split the address once, on entry.
  always_comb begin
    dec      = '0;
    dec.op   = op_e'(func_i);
    dec.done = fill_complete_i;
    dec.word = address_i[OffW-1:2];
    dec.idx  = address_i[OffW+IdxW-1:OffW];
    dec.tag  = address_i[AddrW-1:OffW+IdxW];
    dec.pos  = address_i[PosW-1:0];
    dec.data = fill_data_i;
    dec.way  = fill_way_i;
  end

  assign in_stall_o   = (count_q == QCntW'(QueueDepth));
  assign push         = in_valid_i && !in_stall_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= dec;
    end
  end

endmodule

/* rtl/twrcl_back.sv */
module twrcl_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    head_valid_i,
  input  twrcl_pkg::item_t        head_i,
  output logic                    pop_o,
  output logic                    res_valid_o,
  output twrcl_pkg::result_t      res_o,
  input  logic                    res_stall_i
);

  import twrcl_pkg::*;

  state_e  state_q, state_d;
  item_t   cur_q, cur_d;
  logic    way_q, way_d;
  logic    pending_q, pending_d;
  logic    res_valid_q, res_valid_d;
  result_t res_q, res_d;
  logic    res_load;

  // Per-set valid bits and LRU bit live in one RAM, cleared after reset.
  logic                 clr_busy_q, clr_busy_d;
  logic [IdxW-1:0]      clr_q, clr_d;
  logic                 meta_we, meta_wr;
  logic [IdxW-1:0]      meta_waddr;
  logic [NumWays:0]     meta_wdata, meta_rd;
  logic [NumWays-1:0]   vld_rd, vld_new;
  logic                 lru_rd, lru_new;

  logic                 tag_re;
  logic [NumWays-1:0]   tag_we;
  logic [TagW-1:0]      tag_rd [NumWays];
  logic                 data_re;
  logic [NumWays-1:0]   data_we;
  logic [DataW-1:0]     data_rd [NumWays];
  logic [IdxW-1:0]      tag_raddr;

  logic hit0, hit1, hit_any, res_free, stall_lookup;

  for (genvar g = 0; g < NumWays; g++) begin : g_way
    twrcl_ram #(.Width(TagW), .Depth(Sets)) u_tag_ram (
      .clk_i   (clk_i),
      .we_i    (tag_we[g]),
      .waddr_i (cur_q.idx),
      .wdata_i (cur_q.tag),
      .re_i    (tag_re),
      .raddr_i (tag_raddr),
      .rdata_o (tag_rd[g])
    );
    twrcl_ram #(.Width(DataW), .Depth(WayWords)) u_data_ram (
      .clk_i   (clk_i),
      .we_i    (data_we[g]),
      .waddr_i (head_i.pos),
      .wdata_i (head_i.data),
      .re_i    (data_re),
      .raddr_i ({cur_q.idx, cur_q.word}),
      .rdata_o (data_rd[g])
    );
  end

  twrcl_ram #(.Width(NumWays + 1), .Depth(Sets)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_wr),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .re_i    (tag_re),
    .raddr_i (tag_raddr),
    .rdata_o (meta_rd)
  );

  assign vld_rd     = meta_rd[NumWays:1];
  assign lru_rd     = meta_rd[0];
  assign meta_wr    = meta_we || clr_busy_q;
  assign meta_waddr = clr_busy_q ? clr_q : cur_q.idx;
  assign meta_wdata = clr_busy_q ? '0 : {vld_new, lru_new};

  // Sweep every set once after reset.
  always_comb begin
    clr_d      = clr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  assign tag_raddr    = head_i.idx;
  assign res_free     = !res_valid_q || !res_stall_i;
  assign pop_o        = (state_q == ST_IDLE) && !clr_busy_q && head_valid_i && res_free;
  // A lookup that finds a fill still outstanding answers at once.
  assign stall_lookup = pending_q && !head_i.done;
  assign hit0         = vld_rd[0] && (tag_rd[0] == cur_q.tag);
  assign hit1         = vld_rd[1] && (tag_rd[1] == cur_q.tag);
  assign hit_any      = hit0 || hit1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o && (head_i.op == OP_LOOKUP) && !stall_lookup) begin
          state_d = ST_TAG;
        end
      end
      ST_TAG:  state_d = hit_any ? ST_DATA : ST_IDLE;
      ST_DATA: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cur_d     = cur_q;
    way_d     = way_q;
    pending_d = pending_q;
    res_d     = res_q;
    res_load  = 1'b0;
    tag_re    = 1'b0;
    tag_we    = '0;
    data_re   = 1'b0;
    data_we   = '0;
    meta_we   = 1'b0;
    vld_new   = vld_rd;
    lru_new   = lru_rd;
    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          cur_d = head_i;
          if (head_i.done) begin
            pending_d = 1'b0;
          end
          if (head_i.op == OP_FILL) begin
            data_we[head_i.way] = 1'b1;
            res_d    = '0;
            res_load = 1'b1;
          end else if (stall_lookup) begin
            res_d         = '0;
            res_d.waiting = 1'b1;
            res_load      = 1'b1;
          end else begin
            tag_re = 1'b1;
          end
        end
      end
      ST_TAG: begin
        meta_we = 1'b1;
        if (hit_any) begin
          way_d   = !hit0;
          lru_new = !hit0;
          data_re = 1'b1;
        end else begin
          // Replace the way not used most recently and wait for its fill.
          lru_new               = !lru_rd;
          vld_new[!lru_rd]      = 1'b1;
          tag_we[!lru_rd]       = 1'b1;
          pending_d             = 1'b1;
          res_d                 = '0;
          res_d.fill_request    = 1'b1;
          res_d.request_address = {cur_q.tag, cur_q.idx, OffW'(0)};
          res_d.request_way     = !lru_rd;
          res_load              = 1'b1;
        end
      end
      ST_DATA: begin
        res_d           = '0;
        res_d.read_data = data_rd[way_q];
        res_d.hit       = 1'b1;
        res_load        = 1'b1;
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  assign res_valid_d = res_load || (res_valid_q && res_stall_i);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pending_q   <= 1'b0;
      res_valid_q <= 1'b0;
      clr_busy_q  <= 1'b1;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      pending_q   <= pending_d;
      res_valid_q <= res_valid_d;
      clr_busy_q  <= clr_busy_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    way_q <= way_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

endmodule

/* rtl/two_way_readonly_cache_lookup_core.sv */
// Two-way set-associative read-only cache, LRU replacement per set.
// Input channel (in_valid_i / in_stall_o): one request per handshake, either
// a lookup (func_i = 0, byte address) or a fill word (func_i = 1, word
// position within the way in the low address bits, fill_data_i, fill_way_i).
// fill_complete_i on any request clears an outstanding line fill first.
// Output channel (out_valid_o / out_stall_i): exactly one result per request,
// in order. A miss reports fill_request_o with a line-aligned address and the
// victim way; lookups then answer waiting_o until a completion is seen.
// A two-entry queue sits between the decoding front end and the back end.
// The back end finishes each request before it takes the next: a fill or a
// waiting lookup loads the result as it is popped, a miss first reads the
// tag RAM, and a hit reads the tag RAM and then the data RAM.
// Reset clears the pending flag and the queue; the back end then writes zero
// to the valid and LRU bits of every set before it takes a request, while the
// queue takes two requests and then stalls. The tag and data RAMs keep
// whatever they hold. When the receiver stalls, the result register holds
// and the queue keeps taking requests until it is full.
module two_way_readonly_cache_lookup_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [26:0] address_i,
  input  logic [31:0] fill_data_i,
  input  logic        fill_way_i,
  input  logic        fill_complete_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        hit_o,
  output logic        fill_request_o,
  output logic [26:0] request_address_o,
  output logic        request_way_o,
  output logic        waiting_o
);

  import twrcl_pkg::*;

  item_t   head;
  logic    head_valid;
  logic    pop;
  result_t res;

  twrcl_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .address_i       (address_i),
    .fill_data_i     (fill_data_i),
    .fill_way_i      (fill_way_i),
    .fill_complete_i (fill_complete_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  twrcl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .res_valid_o  (out_valid_o),
    .res_o        (res),
    .res_stall_i  (out_stall_i)
  );

  assign read_data_o       = res.read_data;
  assign hit_o             = res.hit;
  assign fill_request_o    = res.fill_request;
  assign request_address_o = res.request_address;
  assign request_way_o     = res.request_way;
  assign waiting_o         = res.waiting;

endmodule

/* rtl/twrcl_chk.sv */
`include "assert_macros.svh"

module twrcl_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        func_i,
  input logic [26:0] address_i,
  input logic [31:0] fill_data_i,
  input logic        fill_way_i,
  input logic        fill_complete_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        hit_o,
  input logic        fill_request_o,
  input logic [26:0] request_address_o,
  input logic        request_way_o,
  input logic        waiting_o
);

  import twrcl_pkg::*;

  `ASSERT_CLK(a_one_kind, out_valid_o |-> !(hit_o && fill_request_o) && !(hit_o && waiting_o) && !(fill_request_o && waiting_o), "result claims more than one outcome")
  `ASSERT_CLK(a_miss_data_zero, out_valid_o && !hit_o |-> read_data_o == '0, "read data set without a hit")
  `ASSERT_CLK(a_req_fields, out_valid_o && !fill_request_o |-> request_address_o == '0 && !request_way_o, "request fields set without a fill request")
  `ASSERT_CLK(a_req_aligned, out_valid_o && fill_request_o |-> request_address_o[OffW-1:0] == '0, "fill request address not line aligned")
  `ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o), "stalled result dropped or changed")

endmodule

bind two_way_readonly_cache_lookup_core twrcl_chk u_chk (.*);
